FILE: hw/rtl/qvr_pkg.sv
// Shared constants and control types for the quaternion vector rotator.
`default_nettype none

package qvr_pkg;

  localparam int VEC_WIDTH_DEF      = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;

  // Load strobes for the datapath stages, first stage to last
  typedef struct packed {
    logic prod1;  // q times v products
    logic sum1;   // first Hamilton product sums
    logic prod2;  // t times conj(q) products
    logic acc;    // second Hamilton product sums
    logic fin;    // round, scale and saturate into the output register
  } qvr_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/qvr_datapath.sv
// Five-stage arithmetic pipeline for the vector part of q * (0,v) * conj(q).
`default_nettype none

module qvr_datapath #(
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire                                clk,
  input  qvr_pkg::qvr_ctl_t                  ctl,
  input  wire signed [VEC_WIDTH-1:0]         vec_x,
  input  wire signed [VEC_WIDTH-1:0]         vec_y,
  input  wire signed [VEC_WIDTH-1:0]         vec_z,
  input  wire signed [QUAT_FRAC_BITS+1:0]    quat_w,
  input  wire signed [QUAT_FRAC_BITS+1:0]    quat_x,
  input  wire signed [QUAT_FRAC_BITS+1:0]    quat_y,
  input  wire signed [QUAT_FRAC_BITS+1:0]    quat_z,
  output logic signed [VEC_WIDTH-1:0]        rot_x,
  output logic signed [VEC_WIDTH-1:0]        rot_y,
  output logic signed [VEC_WIDTH-1:0]        rot_z
);

  localparam int QUAT_W = QUAT_FRAC_BITS + 2;
  localparam int P1_W   = VEC_WIDTH + QUAT_W;
  localparam int T_W    = P1_W + 2;
  localparam int P2_W   = T_W + QUAT_W;
  localparam int FULL_W = P2_W + 2;
  // Accumulation wraps at 64 bits, as in the bit-exact definition
  localparam int ACC_W  = (FULL_W > 64) ? 64 : FULL_W;
  localparam int RND_W  = (ACC_W < 64) ? ACC_W + 1 : 64;
  localparam int SH     = 2 * QUAT_FRAC_BITS;
  localparam int RS_W   = RND_W - SH;

  localparam logic signed [RND_W-1:0] RND_HALF =
    {{(RND_W - SH){1'b0}}, 1'b1, {(SH - 1){1'b0}}};

  // Stage 1: products of q and v
  logic signed [P1_W-1:0]   p1_r [12];
  logic signed [QUAT_W-1:0] qw1_r, qx1_r, qy1_r, qz1_r;

  always_ff @(posedge clk) begin
    if (ctl.prod1) begin
      p1_r[0]  <= quat_x * vec_x;
      p1_r[1]  <= quat_y * vec_y;
      p1_r[2]  <= quat_z * vec_z;
      p1_r[3]  <= quat_w * vec_x;
      p1_r[4]  <= quat_y * vec_z;
      p1_r[5]  <= quat_z * vec_y;
      p1_r[6]  <= quat_w * vec_y;
      p1_r[7]  <= quat_x * vec_z;
      p1_r[8]  <= quat_z * vec_x;
      p1_r[9]  <= quat_w * vec_z;
      p1_r[10] <= quat_x * vec_y;
      p1_r[11] <= quat_y * vec_x;
      qw1_r    <= quat_w;
      qx1_r    <= quat_x;
      qy1_r    <= quat_y;
      qz1_r    <= quat_z;
    end
  end

  // Stage 2: t = q * (0,v)
  logic signed [T_W-1:0]    tw_r, tx_r, ty_r, tz_r;
  logic signed [QUAT_W-1:0] qw2_r, qx2_r, qy2_r, qz2_r;

  always_ff @(posedge clk) begin
    if (ctl.sum1) begin
      tw_r  <= -(T_W'(p1_r[0]) + T_W'(p1_r[1]) + T_W'(p1_r[2]));
      tx_r  <= T_W'(p1_r[3]) + T_W'(p1_r[4])  - T_W'(p1_r[5]);
      ty_r  <= T_W'(p1_r[6]) - T_W'(p1_r[7])  + T_W'(p1_r[8]);
      tz_r  <= T_W'(p1_r[9]) + T_W'(p1_r[10]) - T_W'(p1_r[11]);
      qw2_r <= qw1_r;
      qx2_r <= qx1_r;
      qy2_r <= qy1_r;
      qz2_r <= qz1_r;
    end
  end

  // Stage 3: products of t and q; conj(q) signs fold into the sums below
  logic signed [P2_W-1:0] p2_r [12];

  always_ff @(posedge clk) begin
    if (ctl.prod2) begin
      p2_r[0]  <= tw_r * qx2_r;
      p2_r[1]  <= tx_r * qw2_r;
      p2_r[2]  <= ty_r * qz2_r;
      p2_r[3]  <= tz_r * qy2_r;
      p2_r[4]  <= tw_r * qy2_r;
      p2_r[5]  <= tx_r * qz2_r;
      p2_r[6]  <= ty_r * qw2_r;
      p2_r[7]  <= tz_r * qx2_r;
      p2_r[8]  <= tw_r * qz2_r;
      p2_r[9]  <= tx_r * qy2_r;
      p2_r[10] <= ty_r * qx2_r;
      p2_r[11] <= tz_r * qw2_r;
    end
  end

  // Stage 4: vector part of t * conj(q)
  logic signed [FULL_W-1:0] sx_full, sy_full, sz_full;
  logic signed [ACC_W-1:0]  acc_r [3];

  always_comb begin
    sx_full = -FULL_W'(p2_r[0]) + FULL_W'(p2_r[1]) - FULL_W'(p2_r[2]) + FULL_W'(p2_r[3]);
    sy_full = -FULL_W'(p2_r[4]) + FULL_W'(p2_r[5]) + FULL_W'(p2_r[6]) - FULL_W'(p2_r[7]);
    sz_full = -FULL_W'(p2_r[8]) - FULL_W'(p2_r[9]) + FULL_W'(p2_r[10]) + FULL_W'(p2_r[11]);
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      acc_r[0] <= sx_full[ACC_W-1:0];
      acc_r[1] <= sy_full[ACC_W-1:0];
      acc_r[2] <= sz_full[ACC_W-1:0];
    end
  end

  // Stage 5: round half up, drop the fraction, saturate
  logic signed [VEC_WIDTH-1:0] rot_r [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [RND_W-1:0]     rnd;
    logic signed [RS_W-1:0]      rs;
    logic signed [VEC_WIDTH-1:0] sat;

    assign rnd = RND_W'(acc_r[i]) + RND_HALF;
    assign rs  = rnd[RND_W-1:SH];

    if (RS_W > VEC_WIDTH) begin : g_clamp
      localparam logic signed [RS_W-1:0] SAT_HI =
        {{(RS_W - VEC_WIDTH + 1){1'b0}}, {(VEC_WIDTH - 1){1'b1}}};
      localparam logic signed [RS_W-1:0] SAT_LO =
        {{(RS_W - VEC_WIDTH + 1){1'b1}}, {(VEC_WIDTH - 1){1'b0}}};
      always_comb begin
        if (rs > SAT_HI) begin
          sat = SAT_HI[VEC_WIDTH-1:0];
        end else if (rs < SAT_LO) begin
          sat = SAT_LO[VEC_WIDTH-1:0];
        end else begin
          sat = rs[VEC_WIDTH-1:0];
        end
      end
    end else if (RS_W == VEC_WIDTH) begin : g_fit
      assign sat = rs;
    end else begin : g_ext
      assign sat = {{(VEC_WIDTH - RS_W){rs[RS_W-1]}}, rs};
    end

    always_ff @(posedge clk) begin
      if (ctl.fin) begin
        rot_r[i] <= sat;
      end
    end
  end

  assign rot_x = rot_r[0];
  assign rot_y = rot_r[1];
  assign rot_z = rot_r[2];

endmodule

`default_nettype wire

FILE: hw/rtl/quaternion_vector_rotate.sv
// Top level of the quaternion vector rotator: stream handshake and stage valids.
//
// Rotates one signed vector per item by a signed Q2.14 quaternion and returns
// the vector part of q * (0,v) * conj(q), rounded half up and saturated.
// Input channel in_*: tdata carries vec_x, vec_y, vec_z, quat_w, quat_x,
// quat_y, quat_z from the lowest bits up. Result channel out_*: tdata carries
// rot_x, rot_y, rot_z from the lowest bits up.
// Five register stages, the first loaded at the accepting edge: q*v products,
// first sums, t*q products, second sums, round and saturate; out_tvalid rises
// when the last of them is loaded.
// Throughput: one item per cycle while out_tready is high; the twelve t*q
// multipliers are the deepest stage and set the clock, and each stage holds
// exactly one item.
// Each stage carries a valid bit. A stage advances when it is empty or when
// the stage after it advances, so bubbles close up while the output stalls
// and in_tready stays high until all five stages are full.
// When out_tready is low the result holds in the output register and the
// stages behind it fill; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears every valid bit; the pipeline comes
// out of reset empty and ready. The quaternion is not normalized.
`default_nettype none

module quaternion_vector_rotate #(
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z, zero fill
  input  wire  [((3*VEC_WIDTH+4*(QUAT_FRAC_BITS+2)+7)/8)*8-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // rot_x, rot_y, rot_z, zero fill
  output logic [((3*VEC_WIDTH+7)/8)*8-1:0]    out_tdata
);

  localparam int QUAT_W  = QUAT_FRAC_BITS + 2;
  localparam int OUT_W   = 3 * VEC_WIDTH;
  localparam int OUT_BW  = ((OUT_W + 7) / 8) * 8;
  localparam int NSTG    = 5;
  localparam int QOFS    = 3 * VEC_WIDTH;

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG-1:0] adv;
  qvr_pkg::qvr_ctl_t ctl;

  logic signed [VEC_WIDTH-1:0] vec_x, vec_y, vec_z;
  logic signed [QUAT_W-1:0]    quat_w, quat_x, quat_y, quat_z;
  logic signed [VEC_WIDTH-1:0] rot_x, rot_y, rot_z;

  // A stage advances when it is empty or its successor advances
  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_tvalid;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (adv[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.prod1 = adv[0];
  assign ctl.sum1  = adv[1];
  assign ctl.prod2 = adv[2];
  assign ctl.acc   = adv[3];
  assign ctl.fin   = adv[4];

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[NSTG-1];

  assign vec_x  = in_tdata[VEC_WIDTH-1:0];
  assign vec_y  = in_tdata[2*VEC_WIDTH-1:VEC_WIDTH];
  assign vec_z  = in_tdata[3*VEC_WIDTH-1:2*VEC_WIDTH];
  assign quat_w = in_tdata[QOFS+QUAT_W-1:QOFS];
  assign quat_x = in_tdata[QOFS+2*QUAT_W-1:QOFS+QUAT_W];
  assign quat_y = in_tdata[QOFS+3*QUAT_W-1:QOFS+2*QUAT_W];
  assign quat_z = in_tdata[QOFS+4*QUAT_W-1:QOFS+3*QUAT_W];

  qvr_datapath #(
    .VEC_WIDTH      (VEC_WIDTH),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_datapath (
    .clk    (clk),
    .ctl    (ctl),
    .vec_x  (vec_x),
    .vec_y  (vec_y),
    .vec_z  (vec_z),
    .quat_w (quat_w),
    .quat_x (quat_x),
    .quat_y (quat_y),
    .quat_z (quat_z),
    .rot_x  (rot_x),
    .rot_y  (rot_y),
    .rot_z  (rot_z)
  );

  assign out_tdata = OUT_BW'({rot_z, rot_y, rot_x});

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking stream testbench for the quaternion vector rotator.
`default_nettype none

module testbench;

  localparam int VW    = qvr_pkg::VEC_WIDTH_DEF;
  localparam int FRAC  = qvr_pkg::QUAT_FRAC_BITS_DEF;
  localparam int QW    = FRAC + 2;
  localparam int IN_W  = ((3*VW + 4*QW + 7)/8)*8;
  localparam int OUT_W = ((3*VW + 7)/8)*8;
  localparam longint ROT_MAX = (longint'(1) <<< (VW-1)) - 1;
  localparam longint ROT_MIN = -(longint'(1) <<< (VW-1));
  localparam int N_RANDOM  = 1800;
  localparam int HOLD_LEN  = 60;

  typedef logic signed [VW-1:0] comp_t;
  typedef comp_t [2:0] vec3_t;

  typedef struct {
    logic signed [VW-1:0] vx, vy, vz;
    logic signed [QW-1:0] qw, qx, qy, qz;
  } rot_req_t;

  typedef struct {
    rot_req_t req;
    bit       typed;
    vec3_t    res;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  wire              in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  wire              out_tvalid;
  logic             out_tready = 1'b0;
  wire [OUT_W-1:0]  out_tdata;

  quaternion_vector_rotate DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  vec3_t    rotation_q[$];
  dir_row_t dir_table[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_req = 1'b0;
  int       hold_left = 0;
  int       n_errors = 0;
  int       n_results = 0;
  int       n_sat_fields = 0;
  int       n_sent = 0;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  function automatic comp_t scale_sat(input longint acc);
    longint r;
    r = (acc + (longint'(1) <<< (2*FRAC-1))) >>> (2*FRAC);
    if (r > ROT_MAX) r = ROT_MAX;
    else if (r < ROT_MIN) r = ROT_MIN;
    return r[VW-1:0];
  endfunction

  // Vector part of q * (0,v) * conj(q), full precision until the final scale
  function automatic vec3_t rotate_expect(input rot_req_t r);
    longint vx, vy, vz, qw, qx, qy, qz;
    longint tw, tx, ty, tz;
    vec3_t res;
    vx = r.vx; vy = r.vy; vz = r.vz;
    qw = r.qw; qx = r.qx; qy = r.qy; qz = r.qz;
    tw = -qx*vx - qy*vy - qz*vz;
    tx =  qw*vx + qy*vz - qz*vy;
    ty =  qw*vy - qx*vz + qz*vx;
    tz =  qw*vz + qx*vy - qy*vx;
    res[0] = scale_sat(-tw*qx + tx*qw - ty*qz + tz*qy);
    res[1] = scale_sat(-tw*qy + tx*qz + ty*qw - tz*qx);
    res[2] = scale_sat(-tw*qz - tx*qy + ty*qx + tz*qw);
    return res;
  endfunction

  function automatic logic [IN_W-1:0] pack_req(input rot_req_t r);
    logic [IN_W-1:0] d;
    d = '0;
    d[0*VW +: VW] = r.vx;
    d[1*VW +: VW] = r.vy;
    d[2*VW +: VW] = r.vz;
    d[3*VW + 0*QW +: QW] = r.qw;
    d[3*VW + 1*QW +: QW] = r.qx;
    d[3*VW + 2*QW +: QW] = r.qy;
    d[3*VW + 3*QW +: QW] = r.qz;
    return d;
  endfunction

  task automatic add_row(input int vx, input int vy, input int vz, input int qw,
                         input int qx, input int qy, input int qz, input bit typed,
                         input int ex, input int ey, input int ez);
    dir_row_t row;
    row.req.vx = VW'(vx); row.req.vy = VW'(vy); row.req.vz = VW'(vz);
    row.req.qw = QW'(qw); row.req.qx = QW'(qx); row.req.qy = QW'(qy); row.req.qz = QW'(qz);
    row.typed = typed;
    row.res[0] = VW'(ex); row.res[1] = VW'(ey); row.res[2] = VW'(ez);
    dir_table.push_back(row);
  endtask

  function automatic rot_req_t random_req();
    rot_req_t r;
    int kind;
    int s;
    kind = $urandom_range(99);
    r.vx = VW'($urandom); r.vy = VW'($urandom); r.vz = VW'($urandom);
    r.qw = QW'($urandom); r.qx = QW'($urandom); r.qy = QW'($urandom); r.qz = QW'($urandom);
    if (kind < 30) begin
      // quaternion components within +/-12000, mostly unsaturated rotations
      s = $urandom_range(9000, 12000);
      r.qw = QW'($urandom_range(0, 2*s) - s);
      r.qx = QW'($urandom_range(0, 2*s) - s);
      r.qy = QW'($urandom_range(0, 2*s) - s);
      r.qz = QW'($urandom_range(0, 2*s) - s);
    end else if (kind < 40) begin
      r.qw = '0; r.qx = '0; r.qy = '0; r.qz = '0;
    end else if (kind < 50) begin
      // tiny vectors land near rounding halves
      r.vx = VW'($urandom_range(0, 8) - 4);
      r.vy = VW'($urandom_range(0, 8) - 4);
      r.vz = VW'($urandom_range(0, 8) - 4);
    end
    return r;
  endfunction

  task automatic send_req(input rot_req_t r, input bit typed, input vec3_t res);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_req(r);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rotation_q.push_back(typed ? res : rotate_expect(r));
    n_sent++;
  endtask

  // Result side: random stalls, plus one long hold on request
  initial forever begin
    @(negedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    vec3_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      for (int k = 0; k < 3; k++) got[k] = out_tdata[k*VW +: VW];
      if (rotation_q.size() == 0) begin
        flag_error($sformatf("result (%0d,%0d,%0d) with no item pending",
                             $signed(got[0]), $signed(got[1]), $signed(got[2])));
      end else begin
        want = rotation_q.pop_front();
        n_results++;
        for (int k = 0; k < 3; k++) begin
          if (got[k] !== want[k])
            flag_error($sformatf("rot_%s got %0d want %0d", k == 0 ? "x" : k == 1 ? "y" : "z",
                                 $signed(got[k]), $signed(want[k])));
          if ($signed(want[k]) == ROT_MAX || $signed(want[k]) == ROT_MIN) n_sat_fields++;
        end
      end
    end
  end

  initial begin
    rot_req_t r;
    vec3_t    none;
    int       ph;
    none = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // zero quaternion clears everything
    add_row(32767, -32768, 12345, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(-1, -1, -1, 0, 0, 0, 0, 1, 0, 0, 0);
    // identity passes the vector through exactly
    add_row(32767, -32768, 0, 16384, 0, 0, 0, 1, 32767, -32768, 0);
    add_row(1, -1, -1234, 16384, 0, 0, 0, 1, 1, -1, -1234);
    // scale by one quarter: exact halves round up
    add_row(2, -2, 1, 8192, 0, 0, 0, 1, 1, 0, 0);
    add_row(6, -6, -1, 8192, 0, 0, 0, 1, 2, -1, 0);
    // scale by four: saturation both ways
    add_row(32767, -32768, 1, -32768, 0, 0, 0, 1, 32767, -32768, 4);
    add_row(16384, -16385, 0, 32767, 0, 0, 0, 1, 32767, -32768, 0);
    add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0, 0);
    add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0, 0);
    add_row(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 0, 0, 0, 0);
    add_row(100, 200, 300, 0, 16384, 0, 0, 0, 0, 0, 0);
    add_row(100, 200, 300, 0, 0, 16384, 0, 0, 0, 0, 0);
    add_row(100, 200, 300, 0, 0, 0, 16384, 0, 0, 0, 0);
    add_row(1000, -2000, 3000, 11585, 0, 0, 11585, 0, 0, 0, 0);
    add_row(1000, -2000, 3000, 11585, -11585, 0, 0, 0, 0, 0, 0);
    add_row(-500, 700, 0, 11585, 0, 11585, 0, 0, 0, 0, 0);
    add_row(1234, -4321, 777, -16384, 0, 0, 0, 0, 0, 0, 0);
    add_row(-32768, 32767, -1, 0, 0, 0, -32768, 0, 0, 0, 0);
    add_row(16'sh5555, 16'sh2AAA, -16'sh5556, 16'sh5555, -16'sh5556, 16'sh2AAA,
            16'sh1555, 0, 0, 0, 0);
    add_row(-16'sh5556, 16'sh5555, 16'sh2AAA, -16'sh5556, 16'sh5555, -16'sh2AAB,
            -16'sh1556, 0, 0, 0, 0);
    add_row(3, -3, 5, 8000, 8000, -8000, 8000, 0, 0, 0, 0);

    foreach (dir_table[i]) send_req(dir_table[i].req, dir_table[i].typed, dir_table[i].res);

    for (int i = 0; i < N_RANDOM; i++) begin
      ph = i * 4 / N_RANDOM;
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      // long output hold with the input kept busy, so the pipe fills
      if (i == 50) hold_req = 1'b1;
      r = random_req();
      send_req(r, 1'b0, none);
    end

    @(negedge clk) in_tvalid <= 1'b0;
    recv_stall_pct = 0;
    wait (rotation_q.size() == 0);
    repeat (12) @(posedge clk);

    $display("Covered %0d directed and %0d random rotations, %0d results checked,",
             dir_table.size(), N_RANDOM, n_results);
    $display("%0d saturated fields, four idle/stall mixes and one %0d-cycle output hold.",
             n_sat_fields, HOLD_LEN);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout with %0d items sent and %0d results pending", n_sent, rotation_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
